/* sv/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CHK_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define CHK_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* sv/msrm_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package msrm_pkg;
  localparam int SAMPLE_W = 16;
  localparam int GAIN_W   = 15;
  localparam int STEP_W   = 18;
  localparam int CFG_IDX_W = 2;

  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_GAIN    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MUTED   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLED = 2'd2;

  localparam logic [GAIN_W-1:0] GAIN_RESET = 15'd4096;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
endpackage
`default_nettype wire

/* sv/msrm_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
module msrm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* sv/multi_stream_resampling_mixer.sv */
// channel   ports                                              handshake
// input     in_mode in_stream in_left_sample in_right_sample   start, taken when !busy
//           in_rate_step
// output    out_left_out out_right_out                         out_strobe, one cycle
// config    cfg_we cfg_index cfg_data                          written when cfg_we high
//
// a push word leaves busy low
// a tick word steps through the streams in turn; a stream holding two or more frames
// passes RD0, RD1, W1, MR and AR, any other stream RD0 only; each active stream does
// two frame ram reads and two passes through the one shared multiplier
// reset is synchronous on rst_n; the frame ram needs no clearing pass
// the receiver cannot stall; out_strobe marks each result for one cycle
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module multi_stream_resampling_mixer #(
  parameter int STREAMS         = 8,
  parameter int RING_FRAMES     = 4096,
  parameter int PHASE_FRAC_BITS = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic                                in_mode,
  input  wire logic [2:0]                          in_stream,
  input  wire msrm_pkg::sample_t                   in_left_sample,
  input  wire msrm_pkg::sample_t                   in_right_sample,
  input  wire logic [msrm_pkg::STEP_W-1:0]         in_rate_step,
  output logic                                     out_strobe,
  output msrm_pkg::sample_t                        out_left_out,
  output msrm_pkg::sample_t                        out_right_out,
  input  wire logic                                cfg_we,
  input  wire logic [msrm_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  wire logic [msrm_pkg::GAIN_W-1:0]         cfg_data
);
  import msrm_pkg::*;

  localparam int F    = PHASE_FRAC_BITS;
  localparam int SW   = (STREAMS > 1) ? $clog2(STREAMS) : 1;
  localparam int PW   = $clog2(RING_FRAMES);
  localparam int HW   = $clog2(RING_FRAMES + 1);
  localparam int PHW  = F + 3;
  localparam int SUMW = ((PHW > STEP_W) ? PHW : STEP_W) + 1;
  localparam int AW   = F + 22;
  localparam int MA   = AW - (F - 8);
  localparam int MB   = (F + 2 > 16) ? F + 2 : 16;
  localparam int PRW  = MA + MB;
  localparam int DEPTH = STREAMS * RING_FRAMES;
  localparam int AD   = $clog2(DEPTH);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RD0  = 4'd1;
  localparam logic [3:0] S_RD1  = 4'd2;
  localparam logic [3:0] S_W1   = 4'd3;
  localparam logic [3:0] S_MR   = 4'd4;
  localparam logic [3:0] S_AR   = 4'd5;
  localparam logic [3:0] S_GL   = 4'd6;
  localparam logic [3:0] S_GR   = 4'd7;
  localparam logic [3:0] S_OUT  = 4'd8;

  logic [3:0] state_r, state_nxt;
  logic [SW-1:0] cnt_r, cnt_nxt;

  logic [GAIN_W-1:0] gain_r;
  logic muted_r, enabled_r;

  logic [PW-1:0]     wp_r   [STREAMS];
  logic [HW-1:0]     held_r [STREAMS];
  logic [PHW-1:0]    ph_r   [STREAMS];
  logic [STEP_W-1:0] step_r [STREAMS];

  logic [PW-1:0] rd1_r;
  logic [31:0] w0_r, w1_r;
  logic signed [AW-1:0] accl_r, accr_r;
  logic signed [PRW-1:0] prod_r, gl_r;

  logic ram_we;
  logic [AD-1:0] ram_waddr, ram_raddr;
  logic [31:0] ram_wdata, ram_rdata;

  logic accept, push_ok, last;
  logic [SW-1:0] idx;
  logic [HW-1:0] held_c;
  logic [PW-1:0] wp_c, wp_inc, r0, r1;
  logic [PW+1:0] rsum;
  logic [PW-1:0] rptr;
  logic [F:0] f;
  logic signed [MA-1:0] mul_a;
  logic signed [MB-1:0] mul_b;
  logic signed [PRW-1:0] mul_p;
  logic [SUMW-1:0] ph_sum;
  logic [PHW-1:0] ph_sat, ph_new;
  logic [2:0] k, n;
  logic [HW-1:0] hm1;
  logic [GAIN_W-1:0] gain_eff;
  logic signed [16:0] dl, dr;

  function automatic logic [SAMPLE_W-1:0] scale_out(input logic signed [PRW-1:0] v);
    logic [PRW-1:0] m;
    logic [51:0] mc, t;
    logic [SAMPLE_W-1:0] r;
    m = v[PRW-1] ? PRW'(-v) : PRW'(v);
    mc = (m > PRW'(64'h8_0000_0000)) ? 52'h8_0000_0000 : 52'(m);
    t = (mc << 15) - mc;
    r = t[50:35];
    return v[PRW-1] ? SAMPLE_W'(-r) : r;
  endfunction

  assign accept = start && !busy;
  assign busy = (state_r != S_IDLE);
  assign idx = (state_r == S_IDLE) ? SW'(in_stream) : cnt_r;
  assign held_c = held_r[idx];
  assign wp_c = wp_r[idx];
  assign last = (cnt_r == SW'(STREAMS - 1));
  assign push_ok = accept && (in_mode == MODE_PUSH) && enabled_r
                   && (5'(in_stream) < 5'(STREAMS));

  assign wp_inc = (wp_c == PW'(RING_FRAMES - 1)) ? '0 : wp_c + 1'b1;
  assign rsum = (PW+2)'(wp_c) + (PW+2)'(RING_FRAMES) - (PW+2)'(held_c);
  assign r0 = (rsum >= (PW+2)'(RING_FRAMES)) ? PW'(rsum - (PW+2)'(RING_FRAMES)) : PW'(rsum);
  assign r1 = (r0 == PW'(RING_FRAMES - 1)) ? '0 : r0 + 1'b1;

  assign f = (ph_r[cnt_r] > PHW'(1 << F)) ? (F+1)'(1 << F) : ph_r[cnt_r][F:0];
  assign gain_eff = muted_r ? '0 : gain_r;

  assign dl = 17'(signed'(ram_rdata[15:0])) - 17'(signed'(w0_r[15:0]));
  assign dr = 17'(signed'(w1_r[31:16])) - 17'(signed'(w0_r[31:16]));

  always_comb begin
    mul_a = MA'(dl);
    mul_b = MB'(f);
    unique case (state_r)
      S_MR: mul_a = MA'(dr);
      S_GL: begin
        mul_a = accl_r[AW-1:F-8];
        mul_b = MB'(gain_eff);
      end
      S_GR: begin
        mul_a = accr_r[AW-1:F-8];
        mul_b = MB'(gain_eff);
      end
      default: begin
      end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  assign ph_sum = SUMW'(ph_r[cnt_r]) + SUMW'(step_r[cnt_r]);
  assign ph_sat = (ph_sum > SUMW'({PHW{1'b1}})) ? '1 : ph_sum[PHW-1:0];
  assign k = ph_sat[PHW-1:F];
  assign hm1 = held_c - 1'b1;
  assign n = (HW'(k) < hm1) ? k : hm1[2:0];
  assign ph_new = ph_sat - {n, {F{1'b0}}};

  assign rptr = (state_r == S_RD1) ? rd1_r : r0;
  assign ram_raddr = AD'(cnt_r) * AD'(RING_FRAMES) + AD'(rptr);
  assign ram_waddr = AD'(idx) * AD'(RING_FRAMES) + AD'(wp_c);
  assign ram_we = push_ok && (held_c < HW'(RING_FRAMES));
  assign ram_wdata = {in_right_sample, in_left_sample};

  msrm_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept && in_mode == MODE_TICK) begin
          state_nxt = S_RD0;
          cnt_nxt = '0;
        end
      end
      S_RD0: begin
        if (held_c < HW'(2)) begin
          if (last) begin
            state_nxt = S_GL;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end else begin
          state_nxt = S_RD1;
        end
      end
      S_RD1: state_nxt = S_W1;
      S_W1:  state_nxt = S_MR;
      S_MR:  state_nxt = S_AR;
      S_AR: begin
        if (last) begin
          state_nxt = S_GL;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
          state_nxt = S_RD0;
        end
      end
      S_GL:  state_nxt = S_GR;
      S_GR:  state_nxt = S_OUT;
      S_OUT: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r <= '0;
      gain_r <= GAIN_RESET;
      muted_r <= 1'b0;
      enabled_r <= 1'b1;
      out_strobe <= 1'b0;
      for (int i = 0; i < STREAMS; i++) begin
        wp_r[i] <= '0;
        held_r[i] <= '0;
        ph_r[i] <= '0;
        step_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      cnt_r <= cnt_nxt;
      out_strobe <= (state_r == S_OUT);
      if (cfg_we) begin
        case (cfg_index)
          CFG_GAIN:    gain_r <= cfg_data;
          CFG_MUTED:   muted_r <= cfg_data[0];
          CFG_ENABLED: enabled_r <= cfg_data[0];
          default: begin
          end
        endcase
      end
      if (push_ok) begin
        step_r[idx] <= in_rate_step;
        if (ram_we) begin
          wp_r[idx] <= wp_inc;
          held_r[idx] <= held_c + 1'b1;
        end
      end
      if (state_r == S_AR) begin
        ph_r[cnt_r] <= ph_new;
        held_r[cnt_r] <= held_c - HW'(n);
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        accl_r <= '0;
        accr_r <= '0;
      end
      S_RD0: rd1_r <= r1;
      S_RD1: w0_r <= ram_rdata;
      S_W1: begin
        w1_r <= ram_rdata;
        prod_r <= mul_p;
      end
      S_MR: begin
        accl_r <= accl_r + (AW'(signed'(w0_r[15:0])) <<< F) + AW'(prod_r);
        prod_r <= mul_p;
      end
      S_AR: accr_r <= accr_r + (AW'(signed'(w0_r[31:16])) <<< F) + AW'(prod_r);
      S_GL: prod_r <= mul_p;
      S_GR: begin
        gl_r <= prod_r;
        prod_r <= mul_p;
      end
      S_OUT: begin
        out_left_out <= scale_out(gl_r);
        out_right_out <= scale_out(prod_r);
      end
      default: begin
      end
    endcase
  end

  `CHK_NEXT(a_tick_goes_busy, accept && in_mode == MODE_TICK, busy)
  `CHK_NOW(a_idle_after_out, out_strobe, !busy)
  `CHK_NOW(a_push_not_busy, push_ok, state_r == S_IDLE)
  `CHK_NOW(a_held_bounded, 1'b1, held_c <= HW'(RING_FRAMES))
endmodule
`default_nettype wire

/* tb/sv/multi_stream_resampling_mixer_tb.sv */
`timescale 1ns / 1ps
module multi_stream_resampling_mixer_tb;
  import msrm_pkg::*;

  localparam int NSTR = 8;
  localparam int RING = 4096;
  localparam longint PH_ONE = 64'd65536;
  localparam longint PH_MAX = 64'd524287;
  localparam longint FULL = 64'sd1 << 35;

  typedef struct {
    logic    mode;
    logic [2:0] stream;
    sample_t lsmp;
    sample_t rsmp;
    logic [STEP_W-1:0] step;
    bit      typed;
    sample_t lexp;
    sample_t rexp;
  } stim_row_t;

  typedef struct {
    sample_t l;
    sample_t r;
  } mix_frame_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_mode = 1'b0;
  logic [2:0] in_stream = '0;
  sample_t in_left_sample = '0;
  sample_t in_right_sample = '0;
  logic [STEP_W-1:0] in_rate_step = '0;
  logic out_strobe;
  sample_t out_left_out;
  sample_t out_right_out;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [GAIN_W-1:0] cfg_data = '0;

  logic [31:0] ring_q[NSTR][$];
  longint phase_m[NSTR];
  longint step_m[NSTR];
  longint gain_m;
  bit muted_m;
  bit enabled_m;
  mix_frame_t mix_q[$];
  int errors = 0;
  bit idling = 1'b1;

  multi_stream_resampling_mixer u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_mode(in_mode), .in_stream(in_stream),
    .in_left_sample(in_left_sample), .in_right_sample(in_right_sample),
    .in_rate_step(in_rate_step), .out_strobe(out_strobe),
    .out_left_out(out_left_out), .out_right_out(out_right_out),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic sample_t to_out(longint v);
    longint m;
    longint q;
    m = (v < 0) ? -v : v;
    if (m > FULL) m = FULL;
    q = (m * 32767) >>> 35;
    if (v < 0) q = -q;
    return sample_t'(q[15:0]);
  endfunction

  function automatic mix_frame_t mix_tick();
    longint accl;
    longint accr;
    longint f;
    longint ph;
    longint l0, l1, r0, r1;
    longint g;
    mix_frame_t res;
    accl = 0;
    accr = 0;
    for (int s = 0; s < NSTR; s++) begin
      if (ring_q[s].size() >= 2) begin
        l0 = longint'(sample_t'(ring_q[s][0][15:0]));
        r0 = longint'(sample_t'(ring_q[s][0][31:16]));
        l1 = longint'(sample_t'(ring_q[s][1][15:0]));
        r1 = longint'(sample_t'(ring_q[s][1][31:16]));
        ph = phase_m[s];
        f = (ph > PH_ONE) ? PH_ONE : ph;
        accl += l0 * PH_ONE + (l1 - l0) * f;
        accr += r0 * PH_ONE + (r1 - r0) * f;
        ph += step_m[s];
        if (ph > PH_MAX) ph = PH_MAX;
        while (ph >= PH_ONE && ring_q[s].size() >= 2) begin
          ph -= PH_ONE;
          void'(ring_q[s].pop_front());
        end
        phase_m[s] = ph;
      end
    end
    g = muted_m ? 0 : gain_m;
    res.l = to_out((accl >>> 8) * g);
    res.r = to_out((accr >>> 8) * g);
    return res;
  endfunction

  // push updates the ring while enabled, tick queues the expected mixed frame
  function automatic void mix_predict(stim_row_t w);
    if (w.mode == MODE_TICK) begin
      if (w.typed) begin
        void'(mix_tick());
        mix_q.push_back('{l: w.lexp, r: w.rexp});
      end else begin
        mix_q.push_back(mix_tick());
      end
    end else if (enabled_m) begin
      if (ring_q[w.stream].size() < RING)
        ring_q[w.stream].push_back({w.rsmp, w.lsmp});
      step_m[w.stream] = longint'(w.step);
    end
  endfunction

  task automatic send_word(stim_row_t w);
    int gap;
    if (idling && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_mode <= w.mode;
    in_stream <= w.stream;
    in_left_sample <= w.lsmp;
    in_right_sample <= w.rsmp;
    in_rate_step <= w.step;
    @(posedge clk);
    while (busy) @(posedge clk);
    mix_predict(w);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (mix_q.size() != 0 || busy) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic set_regs(logic [GAIN_W-1:0] g, bit m, bit e);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_index <= CFG_GAIN;
    cfg_data <= g;
    @(posedge clk);
    cfg_index <= CFG_MUTED;
    cfg_data <= GAIN_W'(m);
    @(posedge clk);
    cfg_index <= CFG_ENABLED;
    cfg_data <= GAIN_W'(e);
    @(posedge clk);
    cfg_we <= 1'b0;
    gain_m = longint'(g);
    muted_m = m;
    enabled_m = e;
  endtask

  function automatic stim_row_t rand_word();
    stim_row_t w;
    w.mode = ($urandom_range(0, 9) < 6) ? MODE_PUSH : MODE_TICK;
    w.stream = 3'($urandom_range(0, 7));
    w.lsmp = sample_t'($urandom_range(0, 65535));
    w.rsmp = sample_t'($urandom_range(0, 65535));
    case ($urandom_range(0, 3))
      0: w.step = STEP_W'($urandom_range(0, 262143));
      1: w.step = STEP_W'($urandom_range(0, 16383));
      default: w.step = STEP_W'($urandom_range(16384, 131071));
    endcase
    w.typed = 1'b0;
    w.lexp = '0;
    w.rexp = '0;
    return w;
  endfunction

  always @(posedge clk) begin
    mix_frame_t e;
    if (rst_n && out_strobe) begin
      if (mix_q.size() == 0) begin
        $error("unexpected word left_out=%0d right_out=%0d", out_left_out, out_right_out);
        errors++;
      end else begin
        e = mix_q.pop_front();
        if (out_left_out !== e.l) begin
          $error("left_out expected %0d got %0d", e.l, out_left_out);
          errors++;
        end
        if (out_right_out !== e.r) begin
          $error("right_out expected %0d got %0d", e.r, out_right_out);
          errors++;
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("multi_stream_resampling_mixer_tb NOT OK");
    $finish;
  end

  initial begin
    stim_row_t dir[$];
    stim_row_t w;
    logic [GAIN_W-1:0] gains[6];
    int guard;
    int n;
    for (int s = 0; s < NSTR; s++) begin
      phase_m[s] = 0;
      step_m[s] = 0;
    end
    gain_m = longint'(GAIN_RESET);
    muted_m = 1'b0;
    enabled_m = 1'b1;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    dir.push_back('{MODE_TICK, 3'd0, 16'sd0, 16'sd0, 18'd0, 1'b1, 16'sd0, 16'sd0});
    dir.push_back('{MODE_PUSH, 3'd0, 16'sh7fff, 16'sh8000, 18'h10000, 1'b0, 0, 0});
    dir.push_back('{MODE_PUSH, 3'd0, 16'sh8000, 16'sh7fff, 18'h10000, 1'b0, 0, 0});
    dir.push_back('{MODE_PUSH, 3'd7, 16'sh8000, 16'sh8000, 18'h3ffff, 1'b0, 0, 0});
    dir.push_back('{MODE_PUSH, 3'd7, 16'sh7fff, 16'sh7fff, 18'h3ffff, 1'b0, 0, 0});
    dir.push_back('{MODE_PUSH, 3'd7, 16'sh0000, 16'shffff, 18'h3ffff, 1'b0, 0, 0});
    dir.push_back('{MODE_PUSH, 3'd3, 16'sh1234, 16'shedcb, 18'h08000, 1'b0, 0, 0});
    dir.push_back('{MODE_PUSH, 3'd3, 16'sh5555, 16'shaaaa, 18'h08000, 1'b0, 0, 0});
    dir.push_back('{MODE_PUSH, 3'd5, 16'sh0001, 16'sh0000, 18'h00000, 1'b0, 0, 0});
    for (int k = 0; k < 6; k++)
      dir.push_back('{MODE_TICK, 3'(k + 2), 16'sh7fff, 16'sh8000, 18'h3ffff, 1'b0, 0, 0});
    dir.push_back('{MODE_PUSH, 3'd5, 16'shffff, 16'sh7fff, 18'h00001, 1'b0, 0, 0});
    dir.push_back('{MODE_TICK, 3'd0, 16'sh0000, 16'sh0000, 18'h00000, 1'b0, 0, 0});
    dir.push_back('{MODE_TICK, 3'd1, 16'sh0000, 16'sh0000, 18'h00000, 1'b0, 0, 0});
    foreach (dir[i]) send_word(dir[i]);

    // stack up frames on one ring with a frozen phase
    for (int k = 0; k < 40; k++) begin
      w = rand_word();
      w.mode = MODE_PUSH;
      w.stream = 3'd6;
      w.step = '0;
      send_word(w);
    end
    for (int k = 0; k < 3; k++) begin
      w = rand_word();
      w.mode = MODE_TICK;
      send_word(w);
    end

    gains = '{15'd4096, 15'd32767, 15'd0, 15'd1, 15'd12000, 15'd4096};
    for (int p = 0; p < 6; p++) begin
      set_regs(gains[p], p == 2 || p == 4, p != 3);
      idling = (p < 5);
      n = (p == 3) ? 60 : 180;
      for (int k = 0; k < n; k++) send_word(rand_word());
    end
    set_regs(gains[$urandom_range(0, 5)], 1'b1, 1'b1);
    for (int k = 0; k < 30; k++) send_word(rand_word());

    start <= 1'b0;
    guard = 0;
    while (mix_q.size() != 0 && guard < 10000) begin
      @(posedge clk);
      guard++;
    end
    repeat (60) @(posedge clk);
    if (errors == 0 && mix_q.size() == 0) begin
      $display("multi_stream_resampling_mixer_tb OK");
    end else begin
      $display("multi_stream_resampling_mixer_tb NOT OK");
    end
    $finish;
  end
endmodule

/* sim.f */
+incdir+sv
sv/msrm_pkg.sv
sv/msrm_ram.sv
sv/multi_stream_resampling_mixer.sv
tb/sv/multi_stream_resampling_mixer_tb.sv
